/* rtl/mck_pkg.sv */
// Shared widths, codes, letter table and controller/datapath signal groups for the keyer.
package mck_pkg;

    localparam int CharW   = 8;
    localparam int DurW    = 24;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegDot     = 2'd0;
    localparam logic [CfgIdxW-1:0] RegDash    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegWordGap = 2'd2;

    localparam logic [DurW-1:0] DotReset     = 24'd200000;
    localparam logic [DurW-1:0] DashReset    = 24'd600000;
    localparam logic [DurW-1:0] WordGapReset = 24'd1400000;

    localparam logic [CharW-1:0] CharSpace = 8'h20;
    localparam logic [CharW-1:0] CharLowA  = 8'h61;
    localparam logic [CharW-1:0] CharLowZ  = 8'h7A;

    // high nibble: symbol count, low nibble: symbols, first in highest used bit, 1 = dash
    localparam logic [7:0] LetterCode [26] = '{
        8'h21, 8'h48, 8'h4A, 8'h34, 8'h10, 8'h42, 8'h36, 8'h40, 8'h20, 8'h47, 8'h35,
        8'h44, 8'h23, 8'h22, 8'h37, 8'h46, 8'h4D, 8'h32, 8'h30, 8'h11, 8'h31, 8'h41,
        8'h33, 8'h49, 8'h4B, 8'h4C
    };

    // {count[2:0], symbols left-aligned to bit 3}
    function automatic logic [6:0] letter_lookup(input logic [4:0] idx);
        logic [7:0] code;
        logic [2:0] len;
        logic [3:0] bits;
        begin
            code = (idx < 5'd26) ? LetterCode[idx] : 8'h00;
            len  = code[6:4];
            bits = code[3:0] << (3'd4 - len);
            return {len, bits};
        end
    endfunction

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic coded;
        logic out_free;
        logic seg_last;
    } t_dp_status;

endpackage

/* rtl/mck_in_if.sv */
// Character input channel.
interface mck_in_if;
    logic                       valid;
    logic                       ready;
    logic [mck_pkg::CharW-1:0]  character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

/* rtl/mck_out_if.sv */
// LED segment output channel.
interface mck_out_if;
    logic                      valid;
    logic                      ready;
    logic                      led_on;
    logic [mck_pkg::DurW-1:0]  duration_us;
    logic                      last_segment;

    modport source (output valid, output led_on, output duration_us, output last_segment,
                    input ready);
    modport sink   (input valid, input led_on, input duration_us, input last_segment,
                    output ready);
endinterface

/* rtl/mck_ctrl.sv */
// Keyer controller: takes a character, then steps out its segments one beat at a time.
module mck_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mck_pkg::t_dp_status i_status,
    output mck_pkg::t_dp_cmd    o_cmd
);
    import mck_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic r_state;
    logic n_state;

    assign o_ready    = (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.emit = (r_state == S_BUSY) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_status.coded) n_state = S_BUSY;
            end
            S_BUSY: begin
                if (i_status.out_free && i_status.seg_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/mck_datapath.sv */
// Keyer datapath: timing registers, letter pattern, step counter and output register.
module mck_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mck_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [mck_pkg::DurW-1:0]     i_cfg_data,
    input  logic [mck_pkg::CharW-1:0]    i_character,
    input  mck_pkg::t_dp_cmd             i_cmd,
    output mck_pkg::t_dp_status          o_status,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_led_on,
    output logic [mck_pkg::DurW-1:0]     o_duration_us,
    output logic                         o_last_segment
);
    import mck_pkg::*;

    logic [DurW-1:0] r_dot;
    logic [DurW-1:0] r_dash;
    logic [DurW-1:0] r_word_gap;

    logic            r_space;
    logic [2:0]      r_len;
    logic [3:0]      r_bits;
    logic [3:0]      r_step;

    logic            r_out_valid;
    logic            r_out_led;
    logic [DurW-1:0] r_out_dur;
    logic            r_out_last;

    logic            is_space;
    logic            is_letter;
    logic [CharW-1:0] ch_off;
    logic [6:0]      lut;
    logic            closing;
    logic            sym_dash;
    logic            seg_led;
    logic [DurW-1:0] seg_dur;
    logic            seg_last;

    assign is_space  = (i_character == CharSpace);
    assign is_letter = (i_character >= CharLowA) && (i_character <= CharLowZ);
    assign ch_off    = i_character - CharLowA;
    assign lut       = letter_lookup(ch_off[4:0]);

    // even steps are marks, odd steps the dot gap after them; step 2*len closes the letter
    assign closing  = !r_step[0] && (r_step[3:1] == r_len);
    assign sym_dash = r_bits[2'd3 - r_step[2:1]];
    assign seg_last = r_space || closing;

    always_comb begin
        priority if (r_space) begin
            seg_led = 1'b0;
            seg_dur = r_word_gap;
        end else if (closing) begin
            seg_led = 1'b0;
            seg_dur = r_dash;
        end else if (!r_step[0]) begin
            seg_led = 1'b1;
            seg_dur = sym_dash ? r_dash : r_dot;
        end else begin
            seg_led = 1'b0;
            seg_dur = r_dot;
        end
    end

    assign o_status.coded    = is_space || is_letter;
    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_status.seg_last = seg_last;

    assign o_valid        = r_out_valid;
    assign o_led_on       = r_out_led;
    assign o_duration_us  = r_out_dur;
    assign o_last_segment = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot      <= DotReset;
            r_dash     <= DashReset;
            r_word_gap <= WordGapReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegDot:     r_dot      <= i_cfg_data;
                RegDash:    r_dash     <= i_cfg_data;
                RegWordGap: r_word_gap <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_space <= is_space;
            r_len   <= lut[6:4];
            r_bits  <= lut[3:0];
            r_step  <= 4'd0;
        end else if (i_cmd.emit) begin
            r_step  <= r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_led  <= seg_led;
            r_out_dur  <= seg_dur;
            r_out_last <= seg_last;
        end
    end

endmodule

/* rtl/morse_code_keyer_core.sv */
// Morse keyer: one character in, up to nine LED segments out, one segment per cycle unless
// the output stalls. A character that is taken is loaded into the pattern registers, and
// each segment goes through the single output register. A new character is taken only while
// idle, after the last segment of the one before; an uncoded character is taken and dropped.
// Reset (synchronous, active low) restores the three timing registers and empties the output.
module morse_code_keyer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mck_in_if.sink                       i_char_ch,
    mck_out_if.source                    o_seg_ch,
    input  logic                         i_cfg_we,
    input  logic [mck_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [mck_pkg::DurW-1:0]     i_cfg_data
);
    import mck_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    mck_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_char_ch.valid),
        .o_ready  (i_char_ch.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mck_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_character    (i_char_ch.character),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_seg_ch.valid),
        .i_ready        (o_seg_ch.ready),
        .o_led_on       (o_seg_ch.led_on),
        .o_duration_us  (o_seg_ch.duration_us),
        .o_last_segment (o_seg_ch.last_segment)
    );

endmodule

/* test/morse_code_keyer_core_test.sv */
// Self-checking testbench for the Morse keyer core: predicted LED segments against the DUT.
module morse_code_keyer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mck_pkg::*;

    localparam int CycleLimit = 400000;
    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
    localparam logic [DurW-1:0] DurMax = {DurW{1'b1}};

    typedef struct packed {
        logic            led_on;
        logic [DurW-1:0] duration_us;
        logic            last_segment;
    } t_seg;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [DurW-1:0] i_cfg_data;

    mck_in_if  char_ch ();
    mck_out_if seg_ch ();

    morse_code_keyer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char_ch  (char_ch),
        .o_seg_ch   (seg_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // timing registers as the DUT should hold them
    logic [DurW-1:0] dot_us;
    logic [DurW-1:0] dash_us;
    logic [DurW-1:0] gap_us;

    logic [CharW-1:0] char_backlog [$];
    t_seg             seg_expected [$];

    bit src_idle_en;
    bit snk_idle_en;
    int fail_count;
    int chars_sent;
    int segs_checked;
    int settings_run;
    int cycle_count;

    function automatic void note_fail(input string msg);
        if (fail_count < 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    // dots and dashes per letter, first symbol first
    function automatic string morse_pattern(input logic [4:0] idx);
        case (idx)
            5'd0:  return ".-";
            5'd1:  return "-...";
            5'd2:  return "-.-.";
            5'd3:  return "-..";
            5'd4:  return ".";
            5'd5:  return "..-.";
            5'd6:  return "--.";
            5'd7:  return "....";
            5'd8:  return "..";
            5'd9:  return ".---";
            5'd10: return "-.-";
            5'd11: return ".-..";
            5'd12: return "--";
            5'd13: return "-.";
            5'd14: return "---";
            5'd15: return ".--.";
            5'd16: return "--.-";
            5'd17: return ".-.";
            5'd18: return "...";
            5'd19: return "-";
            5'd20: return "..-";
            5'd21: return "...-";
            5'd22: return ".--";
            5'd23: return "-..-";
            5'd24: return "-.--";
            default: return "--..";
        endcase
    endfunction

    function automatic void predict_segments(input logic [CharW-1:0] ch);
        string pat;
        t_seg  seg;
        if (ch == CharSpace) begin
            seg_expected.push_back('{1'b0, gap_us, 1'b1});
            return;
        end
        if (ch < CharLowA || ch > CharLowZ) return;
        pat = morse_pattern(5'(ch - CharLowA));
        for (int i = 0; i < pat.len(); i++) begin
            seg = '{1'b1, (pat[i] == "-") ? dash_us : dot_us, 1'b0};
            seg_expected.push_back(seg);
            seg = '{1'b0, dot_us, 1'b0};
            seg_expected.push_back(seg);
        end
        seg_expected.push_back('{1'b0, dash_us, 1'b1});
    endfunction

    // character driver
    always @(posedge i_clk) begin : char_driver
        logic             nxt_valid;
        logic [CharW-1:0] nxt_char;
        int               src_gap;
        nxt_valid = char_ch.valid;
        nxt_char  = char_ch.character;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
            src_gap   = 0;
        end else begin
            if (char_ch.valid && char_ch.ready) begin
                predict_segments(char_ch.character);
                void'(char_backlog.pop_front());
                chars_sent++;
            end
            // a beat on offer stays on offer until taken
            if (!(char_ch.valid && !char_ch.ready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    nxt_valid = 1'b0;
                end else if (char_backlog.size() == 0) begin
                    nxt_valid = 1'b0;
                end else if (src_idle_en && $urandom_range(0, 5) == 0) begin
                    src_gap   = $urandom_range(0, 9);
                    nxt_valid = 1'b0;
                end else begin
                    nxt_valid = 1'b1;
                    nxt_char  = char_backlog[0];
                end
            end
        end
        char_ch.valid     <= nxt_valid;
        char_ch.character <= nxt_char;
    end

    // segment monitor with random back-pressure
    always @(posedge i_clk) begin : seg_monitor
        logic rdy;
        int   snk_gap;
        t_seg want;
        if (!i_rst_n) begin
            rdy     = 1'b0;
            snk_gap = 0;
        end else begin
            if (seg_ch.valid && seg_ch.ready) begin
                if (seg_expected.size() == 0) begin
                    note_fail($sformatf("unexpected segment led=%0b dur=%0d last=%0b",
                        seg_ch.led_on, seg_ch.duration_us, seg_ch.last_segment));
                end else begin
                    want = seg_expected.pop_front();
                    if (seg_ch.led_on !== want.led_on
                            || seg_ch.duration_us !== want.duration_us
                            || seg_ch.last_segment !== want.last_segment) begin
                        note_fail($sformatf(
                            "expected led=%0b dur=%0d last=%0b, got led=%0b dur=%0d last=%0b",
                            want.led_on, want.duration_us, want.last_segment,
                            seg_ch.led_on, seg_ch.duration_us, seg_ch.last_segment));
                    end
                    segs_checked++;
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                rdy = 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 9);
                rdy     = 1'b0;
            end else begin
                rdy = 1'b1;
            end
        end
        seg_ch.ready <= rdy;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            RegDot:     dot_us  = val;
            RegDash:    dash_us = val;
            RegWordGap: gap_us  = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [DurW-1:0] dot, input logic [DurW-1:0] dash,
                              input logic [DurW-1:0] gap);
        write_reg(RegDot, dot);
        write_reg(RegDash, dash);
        write_reg(RegWordGap, gap);
        settings_run++;
    endtask

    task automatic push_chars(input string s);
        @(negedge i_clk);
        for (int i = 0; i < s.len(); i++) char_backlog.push_back(s[i]);
    endtask

    // wait for every beat to go through, then idle so the core settles
    task automatic drain();
        while (char_backlog.size() != 0 || seg_expected.size() != 0) @(negedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [DurW-1:0] pick_duration();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DurMax;
            2: return DurW'($urandom_range(1, 16));
            default: return DurW'($urandom);
        endcase
    endfunction

    function automatic logic [CharW-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CharLowA + CharW'($urandom_range(0, 25));
        if (r < 82) return CharSpace;
        return CharW'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input int n);
        set_timing(pick_duration(), pick_duration(), pick_duration());
        if ($urandom_range(0, 1) == 1) write_reg(RegUnused, DurW'($urandom));
        @(negedge i_clk);
        repeat (n) char_backlog.push_back(pick_char());
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = RegDot;
        i_cfg_data       = '0;
        char_ch.valid    = 1'b0;
        char_ch.character = '0;
        seg_ch.ready     = 1'b0;
        dot_us           = DotReset;
        dash_us          = DashReset;
        gap_us           = WordGapReset;
        src_idle_en      = 1'b1;
        snk_idle_en      = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_run = 1;

        // reset timing: shortest and longest letters, space, bytes either side of the coded range
        push_chars("etqaz A0h");
        @(negedge i_clk);
        char_backlog.push_back(8'h00);
        char_backlog.push_back(8'hFF);
        char_backlog.push_back(8'h60);
        char_backlog.push_back(8'h7B);
        char_backlog.push_back(8'h1F);
        char_backlog.push_back(8'h80);
        drain();

        // zero durations still give segments; unused index must not disturb anything
        set_timing('0, '0, '0);
        write_reg(RegUnused, DurMax);
        push_chars("et x");
        drain();

        set_timing(DurMax, DurMax, DurMax);
        push_chars("y b");
        drain();

        src_idle_en = 1'b1; snk_idle_en = 1'b0;
        random_phase(80);
        src_idle_en = 1'b0; snk_idle_en = 1'b1;
        random_phase(80);
        src_idle_en = 1'b1; snk_idle_en = 1'b1;
        random_phase(80);
        random_phase(80);
        random_phase(80);
        // full rate to close
        src_idle_en = 1'b0; snk_idle_en = 1'b0;
        random_phase(70);

        repeat (20) @(posedge i_clk);
        $display("Sent %0d characters across %0d timing settings, %0d segments checked.",
            chars_sent, settings_run, segs_checked);
        $display("Mismatches seen: %0d", fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mck_pkg.sv
rtl/mck_in_if.sv
rtl/mck_out_if.sv
rtl/mck_ctrl.sv
rtl/mck_datapath.sv
rtl/morse_code_keyer_core.sv
test/morse_code_keyer_core_test.sv
